/* design/slp_pkg.sv */
// Shared types and constants for the string-to-long parser.
package slp_pkg;

	localparam int VALUE_BITS = 64;
	localparam int COUNT_BITS = 16;

	localparam int CH_BITS        = 8;
	localparam int RADIX_BITS     = 6;
	localparam int DIGIT_BITS     = 6;
	localparam int OUT_VALUE_BITS = 64;
	localparam int OUT_COUNT_BITS = 16;

	localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_BITS-1:0] RADIX_ONE   = 6'd1;
	localparam logic [RADIX_BITS-1:0] BASE_AUTO   = 6'd0;
	localparam logic [RADIX_BITS-1:0] BASE_MIN    = 6'd2;
	localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
	localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
	localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;

	// non-digit code, above any legal base
	localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd63;
	localparam logic [DIGIT_BITS-1:0] DIGIT_ZERO = 6'd0;

	localparam logic [CH_BITS-1:0] CH_SPACE     = 8'h20;
	localparam logic [CH_BITS-1:0] CH_TAB       = 8'h09;
	localparam logic [CH_BITS-1:0] CH_CR        = 8'h0D;
	localparam logic [CH_BITS-1:0] CH_MINUS     = 8'h2D;
	localparam logic [CH_BITS-1:0] CH_PLUS      = 8'h2B;
	localparam logic [CH_BITS-1:0] CH_LOWER_X   = 8'h78;
	localparam logic [CH_BITS-1:0] CH_UPPER_X   = 8'h58;
	localparam logic [CH_BITS-1:0] CH_DIG_0     = 8'h30;
	localparam logic [CH_BITS-1:0] CH_DIG_9     = 8'h39;
	localparam logic [CH_BITS-1:0] CH_UPPER_A   = 8'h41;
	localparam logic [CH_BITS-1:0] CH_UPPER_Z   = 8'h5A;
	localparam logic [CH_BITS-1:0] CH_LOWER_A   = 8'h61;
	localparam logic [CH_BITS-1:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [CH_BITS-1:0] CH_UPPER_OFS = 8'd55; // 'A' - 10
	localparam logic [CH_BITS-1:0] CH_LOWER_OFS = 8'd87; // 'a' - 10

	localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGN,
		PH_ZERO,
		PH_XSEEN,
		PH_DIGITS
	} phase_t;

	// classified character word passed from front to back
	typedef struct packed {
		logic                  first;
		logic                  bad_radix;
		logic [RADIX_BITS-1:0] radix;
		logic [DIGIT_BITS-1:0] digit;
		logic                  is_space;
		logic                  is_sign;
		logic                  is_minus;
		logic                  is_x;
	} word_t;

endpackage

/* design/slp_front.sv */
// Front end: radix register, input handshake and character classification.
module slp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [slp_pkg::RADIX_BITS-1:0]  cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [slp_pkg::CH_BITS-1:0]     ch,
	input  logic                            first,
	input  logic                            fifo_full,
	output logic                            push,
	output slp_pkg::word_t                  push_word
);

	logic [slp_pkg::RADIX_BITS-1:0] radix_q;

	function automatic logic [slp_pkg::DIGIT_BITS-1:0] digit_of(
		input logic [slp_pkg::CH_BITS-1:0] c
	);
		logic [slp_pkg::CH_BITS-1:0] d;
		d = {slp_pkg::CH_BITS{1'b1}};
		if (c >= slp_pkg::CH_DIG_0 && c <= slp_pkg::CH_DIG_9) begin
			d = c - slp_pkg::CH_DIG_0;
		end else if (c >= slp_pkg::CH_UPPER_A && c <= slp_pkg::CH_UPPER_Z) begin
			d = c - slp_pkg::CH_UPPER_OFS;
		end else if (c >= slp_pkg::CH_LOWER_A && c <= slp_pkg::CH_LOWER_Z) begin
			d = c - slp_pkg::CH_LOWER_OFS;
		end
		if (d == {slp_pkg::CH_BITS{1'b1}}) begin
			return slp_pkg::DIGIT_NONE;
		end
		return d[slp_pkg::DIGIT_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= slp_pkg::RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		push_word.first     = first;
		push_word.bad_radix = (radix_q == slp_pkg::RADIX_ONE) || (radix_q > slp_pkg::RADIX_MAX);
		push_word.radix     = radix_q;
		push_word.digit     = digit_of(ch);
		push_word.is_space  = (ch == slp_pkg::CH_SPACE) ||
			(ch >= slp_pkg::CH_TAB && ch <= slp_pkg::CH_CR);
		push_word.is_sign   = (ch == slp_pkg::CH_MINUS) || (ch == slp_pkg::CH_PLUS);
		push_word.is_minus  = (ch == slp_pkg::CH_MINUS);
		push_word.is_x      = (ch == slp_pkg::CH_LOWER_X) || (ch == slp_pkg::CH_UPPER_X);
	end

endmodule

/* design/slp_fifo.sv */
// Short queue of classified words between front and back.
module slp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slp_pkg::word_t push_word,
	output logic           full,
	output logic           rd_valid,
	input  logic           pop,
	output slp_pkg::word_t rd_word
);

	slp_pkg::word_t                     mem_q [slp_pkg::FIFO_DEPTH];
	logic [slp_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_q;
	logic [slp_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_q;
	logic [slp_pkg::FIFO_PTR_BITS:0]    cnt_q;
	logic                               do_pop;

	assign full     = (cnt_q == (slp_pkg::FIFO_PTR_BITS+1)'(slp_pkg::FIFO_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_word  = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (slp_pkg::FIFO_PTR_BITS+1)'(slp_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

/* design/slp_back.sv */
// Back end: parse state machine, digit multiply-add and result register.
module slp_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_valid,
	input  slp_pkg::word_t                       rd_word,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [slp_pkg::OUT_VALUE_BITS-1:0] value,
	output logic                                 converted,
	output logic                                 overflow,
	output logic [slp_pkg::OUT_COUNT_BITS-1:0]   consumed
);

	localparam int VB = slp_pkg::VALUE_BITS;
	localparam int CB = slp_pkg::COUNT_BITS;
	localparam int RB = slp_pkg::RADIX_BITS;
	localparam int PW = VB + RB + 1;

	slp_pkg::phase_t phase_q, phase_e, phase_d;
	logic            neg_q, sat_q, any_q;
	logic [RB-1:0]   base_q;
	logic [VB-1:0]   acc_q;
	logic [CB-1:0]   pos_q, endp_q;

	logic            neg_e, sat_e, any_e;
	logic [RB-1:0]   base_e;
	logic [VB-1:0]   acc_e;
	logic [CB-1:0]   pos_b, pos_e, endp_e;
	logic            first_bad;

	logic            do_emit, do_digit, do_zero, do_sign;
	logic [RB-1:0]   b_try;
	logic            digit_ok, take, emit, ovf;

	logic [VB+RB-1:0] mul;
	logic [PW-1:0]    sum, limit;
	logic [VB-1:0]    value_n;

	logic                               out_valid_q;
	logic [VB-1:0]                      value_q;
	logic                               converted_q, overflow_q;
	logic [slp_pkg::OUT_COUNT_BITS-1:0] consumed_q;

	assign pop = rd_valid && (!out_valid_q || !out_stall);

	// a first-marked word restarts the parse before the character is looked at
	always_comb begin
		phase_e = rd_word.first ? slp_pkg::PH_SPACE : phase_q;
		neg_e   = rd_word.first ? 1'b0 : neg_q;
		sat_e   = rd_word.first ? 1'b0 : sat_q;
		any_e   = rd_word.first ? 1'b0 : any_q;
		base_e  = rd_word.first ? rd_word.radix : base_q;
		acc_e   = rd_word.first ? '0 : acc_q;
		pos_b   = rd_word.first ? '0 : pos_q;
		endp_e  = rd_word.first ? '0 : endp_q;
	end

	assign first_bad = rd_word.first && rd_word.bad_radix;
	assign pos_e     = pos_b + CB'(pos_b != slp_pkg::COUNT_MAX);

	// FSM outputs
	always_comb begin
		do_emit  = 1'b0;
		do_digit = 1'b0;
		do_zero  = 1'b0;
		do_sign  = 1'b0;
		b_try    = base_e;
		if (first_bad) begin
			do_emit = 1'b1;
		end else begin
			unique case (phase_e)
				slp_pkg::PH_IDLE: begin
				end
				slp_pkg::PH_SPACE, slp_pkg::PH_SIGN: begin
					if (phase_e == slp_pkg::PH_SPACE && rd_word.is_space) begin
					end else if (phase_e == slp_pkg::PH_SPACE && rd_word.is_sign) begin
						do_sign = 1'b1;
					end else if (rd_word.digit == slp_pkg::DIGIT_ZERO &&
						(base_e == slp_pkg::BASE_AUTO || base_e == slp_pkg::BASE_HEX)) begin
						do_zero = 1'b1;
					end else begin
						do_digit = 1'b1;
						b_try    = (base_e == slp_pkg::BASE_AUTO) ? slp_pkg::BASE_DEC : base_e;
					end
				end
				slp_pkg::PH_ZERO: begin
					if (!rd_word.is_x) begin
						do_digit = 1'b1;
						b_try    = (base_e == slp_pkg::BASE_AUTO) ? slp_pkg::BASE_OCT : base_e;
					end
				end
				slp_pkg::PH_XSEEN: begin
					do_digit = 1'b1;
					b_try    = slp_pkg::BASE_HEX;
				end
				slp_pkg::PH_DIGITS: begin
					do_digit = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign digit_ok = (b_try >= slp_pkg::BASE_MIN) && (rd_word.digit < b_try);
	assign take     = do_digit && digit_ok;
	assign emit     = do_emit || (do_digit && !digit_ok);

	// next state
	always_comb begin
		if (emit) begin
			phase_d = slp_pkg::PH_IDLE;
		end else if (take) begin
			phase_d = slp_pkg::PH_DIGITS;
		end else if (do_zero) begin
			phase_d = slp_pkg::PH_ZERO;
		end else if (do_sign) begin
			phase_d = slp_pkg::PH_SIGN;
		end else if (phase_e == slp_pkg::PH_ZERO) begin
			phase_d = slp_pkg::PH_XSEEN;
		end else begin
			phase_d = phase_e;
		end
	end

	// acc*base + d > limit  is the same test as  acc > (limit - d) / base
	assign mul   = acc_e * b_try;
	assign sum   = PW'(mul) + PW'(rd_word.digit);
	assign limit = PW'(slp_pkg::VALUE_MAX) + PW'(neg_e);
	assign ovf   = (sum > limit);

	always_comb begin
		if (sat_e) begin
			value_n = neg_e ? slp_pkg::VALUE_MIN : slp_pkg::VALUE_MAX;
		end else begin
			value_n = neg_e ? (VB'(0) - acc_e) : acc_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slp_pkg::PH_IDLE;
			neg_q   <= 1'b0;
			sat_q   <= 1'b0;
			any_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			pos_q   <= '0;
			endp_q  <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			neg_q   <= do_sign ? rd_word.is_minus : neg_e;
			sat_q   <= sat_e || (take && ovf);
			any_q   <= any_e || take || do_zero;
			base_q  <= do_digit ? b_try : base_e;
			acc_q   <= (take && !sat_e && !ovf) ? sum[VB-1:0] : acc_e;
			pos_q   <= (phase_e != slp_pkg::PH_IDLE) ? pos_e : pos_b;
			endp_q  <= (take || do_zero) ? pos_e : endp_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			value_q     <= any_e ? value_n : '0;
			converted_q <= any_e;
			overflow_q  <= sat_e;
			consumed_q  <= any_e ? slp_pkg::OUT_COUNT_BITS'(endp_e) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = slp_pkg::OUT_VALUE_BITS'(signed'(value_q));
	assign converted = converted_q;
	assign overflow  = overflow_q;
	assign consumed  = consumed_q;

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (out_valid_q && phase_q == slp_pkg::PH_IDLE))
		else $error("result word not loaded or parser not idle");

	a_ovf_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overflow_q) |-> converted_q)
		else $error("overflow without a converted digit");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !converted_q) |-> (value_q == '0 && consumed_q == '0))
		else $error("empty conversion with nonzero value or count");

endmodule

/* design/string_to_long_parser_unit.sv */
// Top level of the streaming strtol-style parser.
// Takes one character word per clock while the queue has room: the front end
// classifies each byte into a four-word queue, the back end runs the parse
// state machine on one queued byte per clock unless the output stalls and
// loads the result register, so the output can stall while input keeps
// flowing until the queue fills. The byte that ends the number (first
// non-digit, NUL, or a first-marked byte with a bad radix) loads the result
// when popped. The clock period is set by the back end's digit step: a 64
// by 6 bit multiply-add of the accumulator followed by the limit compare.
// The radix register is sampled when a first-marked byte is accepted.
module string_to_long_parser_unit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [slp_pkg::RADIX_BITS-1:0]            cfg_wr_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [slp_pkg::CH_BITS-1:0]               ch,
	input  logic                                      first,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [slp_pkg::OUT_VALUE_BITS-1:0] value,
	output logic                                      converted,
	output logic                                      overflow,
	output logic [slp_pkg::OUT_COUNT_BITS-1:0]        consumed
);

	logic           fifo_full;
	logic           push;
	slp_pkg::word_t push_word;
	logic           rd_valid;
	logic           pop;
	slp_pkg::word_t rd_word;

	slp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.first       (first),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_word   (push_word)
	);

	slp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (fifo_full),
		.rd_valid  (rd_valid),
		.pop       (pop),
		.rd_word   (rd_word)
	);

	slp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (rd_valid),
		.rd_word   (rd_word),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.converted (converted),
		.overflow  (overflow),
		.consumed  (consumed)
	);

endmodule

/* sim/string_to_long_parser_unit_test.sv */
// Self-checking testbench for the streaming string-to-long parser unit.
module string_to_long_parser_unit_test;
	import slp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_ITEMS   = 110;

	localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_BITS-1:0] CH_COMMA = 8'h2C;
	localparam logic [CH_BITS-1:0] CH_BANG  = 8'h21;

	typedef struct {
		logic [CH_BITS-1:0] code;
		logic               mark_first;
		int unsigned        gap;
	} char_word_t;

	typedef struct {
		logic [OUT_VALUE_BITS-1:0] value;
		logic                      converted;
		logic                      overflow;
		logic [OUT_COUNT_BITS-1:0] consumed;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [RADIX_BITS-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CH_BITS-1:0] ch = '0;
	logic first = 1'b0;
	logic out_valid;
	logic out_stall;
	logic signed [OUT_VALUE_BITS-1:0] value;
	logic converted;
	logic overflow;
	logic [OUT_COUNT_BITS-1:0] consumed;

	logic rx_pace_stall = 1'b0;
	logic rx_hold = 1'b0;
	assign out_stall = rx_pace_stall | rx_hold;

	string_to_long_parser_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.first       (first),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.converted   (converted),
		.overflow    (overflow),
		.consumed    (consumed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_word_t    chars_pending[$];
	parse_result_t results_due[$];
	int unsigned   mismatches = 0;
	int unsigned   items_queued = 0;
	int unsigned   cycle_count = 0;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;
	bit            hold_phase = 1'b0;
	bit            next_first = 1'b0;

	// parser shadow state
	logic [RADIX_BITS-1:0]     radix_setting = RADIX_RESET;
	phase_t                    p_phase = PH_IDLE;
	logic                      p_neg = 1'b0;
	logic [RADIX_BITS-1:0]     p_base = '0;
	logic [VALUE_BITS-1:0]     p_acc = '0;
	logic                      p_sat = 1'b0;
	logic                      p_any = 1'b0;
	logic [COUNT_BITS-1:0]     p_pos = '0;
	logic [COUNT_BITS-1:0]     p_end = '0;

	function automatic logic [DIGIT_BITS-1:0] digit_code(input logic [CH_BITS-1:0] c);
		if (c >= CH_DIG_0 && c <= CH_DIG_9)
			return DIGIT_BITS'(c - CH_DIG_0);
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			return DIGIT_BITS'(c - CH_UPPER_OFS);
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			return DIGIT_BITS'(c - CH_LOWER_OFS);
		return DIGIT_NONE;
	endfunction

	function automatic bit is_blank(input logic [CH_BITS-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic close_number();
		parse_result_t r;
		if (p_sat)
			r.value = p_neg ? VALUE_MIN : VALUE_MAX;
		else
			r.value = p_neg ? -p_acc : p_acc;
		r.converted = p_any;
		r.overflow  = p_sat;
		r.consumed  = p_any ? p_end : '0;
		results_due.push_back(r);
		p_phase = PH_IDLE;
	endtask

	task automatic take_digit(input logic [CH_BITS-1:0] c);
		logic [DIGIT_BITS-1:0] d;
		logic [VALUE_BITS-1:0] lim;
		d = digit_code(c);
		if (p_base < BASE_MIN || d >= p_base) begin
			close_number();
			return;
		end
		// negative side may reach one past the positive limit
		lim = VALUE_MAX + (p_neg ? 64'd1 : 64'd0);
		if (!p_sat) begin
			if (p_acc > (lim - 64'(d)) / 64'(p_base))
				p_sat = 1'b1;
			else
				p_acc = p_acc * 64'(p_base) + 64'(d);
		end
		p_any   = 1'b1;
		p_end   = p_pos;
		p_phase = PH_DIGITS;
	endtask

	task automatic start_number(input logic [CH_BITS-1:0] c);
		if (c == CH_DIG_0 && (p_base == BASE_AUTO || p_base == BASE_HEX)) begin
			p_any   = 1'b1;
			p_end   = p_pos;
			p_phase = PH_ZERO;
			return;
		end
		if (p_base == BASE_AUTO)
			p_base = BASE_DEC;
		take_digit(c);
	endtask

	task automatic parse_char(input logic [CH_BITS-1:0] c, input logic f);
		if (f) begin
			p_neg   = 1'b0;
			p_acc   = '0;
			p_sat   = 1'b0;
			p_any   = 1'b0;
			p_pos   = '0;
			p_end   = '0;
			p_base  = radix_setting;
			p_phase = PH_SPACE;
			if (radix_setting == RADIX_ONE || radix_setting > RADIX_MAX) begin
				close_number();
				return;
			end
		end
		if (p_phase == PH_IDLE)
			return;
		if (p_pos != COUNT_MAX)
			p_pos = p_pos + 1'b1;
		case (p_phase)
			PH_SPACE: begin
				if (c == CH_MINUS || c == CH_PLUS) begin
					p_neg   = (c == CH_MINUS);
					p_phase = PH_SIGN;
				end else if (!is_blank(c)) begin
					start_number(c);
				end
			end
			PH_SIGN: start_number(c);
			PH_ZERO: begin
				if (c == CH_LOWER_X || c == CH_UPPER_X) begin
					p_phase = PH_XSEEN;
				end else begin
					if (p_base == BASE_AUTO)
						p_base = BASE_OCT;
					take_digit(c);
				end
			end
			PH_XSEEN: begin
				p_base = BASE_HEX;
				take_digit(c);
			end
			PH_DIGITS: take_digit(c);
			default: p_phase = PH_IDLE;
		endcase
	endtask

	// driver: one word per handshake, per-word gap taken before it is offered
	char_word_t  next_word;
	bit          have_next = 1'b0;
	int unsigned tx_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
			first <= 1'b0;
			have_next = 1'b0;
			tx_wait = 0;
		end else begin
			if (in_valid && !in_stall)
				parse_char(ch, first);
			if (!in_valid || !in_stall) begin
				if (!have_next && chars_pending.size() != 0) begin
					next_word = chars_pending.pop_front();
					have_next = 1'b1;
					tx_wait = next_word.gap;
				end
				if (have_next && tx_wait == 0) begin
					in_valid <= 1'b1;
					ch <= next_word.code;
					first <= next_word.mark_first;
					have_next = 1'b0;
				end else begin
					in_valid <= 1'b0;
					if (tx_wait != 0)
						tx_wait--;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	// monitor
	parse_result_t want;
	int unsigned   rx_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_pace_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: value %h converted %b overflow %b consumed %h",
						$time, value, converted, overflow, consumed);
				end else begin
					want = results_due.pop_front();
					check_field("value", want.value, value);
					check_field("converted", 64'(want.converted), 64'(converted));
					check_field("overflow", 64'(want.overflow), 64'(overflow));
					check_field("consumed", 64'(want.consumed), 64'(consumed));
				end
				rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			rx_pace_stall <= (rx_wait != 0);
		end
	end

	// long receiver hold-off, counted here so the sender keeps pushing
	int unsigned hold_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
			hold_count <= 0;
		end else if (hold_phase && hold_count < HOLD_CYCLES) begin
			rx_hold <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			rx_hold <= 1'b0;
			if (!hold_phase)
				hold_count <= 0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("string_to_long_parser_unit_test: FAIL");
			$finish;
		end
	end

	task automatic queue_char(input logic [CH_BITS-1:0] c, input logic f);
		char_word_t w;
		w.code = c;
		w.mark_first = f;
		w.gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		chars_pending.push_back(w);
		items_queued++;
	endtask

	task automatic put_char(input logic [CH_BITS-1:0] c);
		queue_char(c, next_first);
		next_first = 1'b0;
	endtask

	task automatic queue_text(input string s, input logic [CH_BITS-1:0] tail, input bit closed = 1'b1);
		next_first = 1'b1;
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
		if (closed)
			put_char(tail);
	endtask

	function automatic logic [CH_BITS-1:0] digit_char(input int unsigned v);
		if (v < 10)
			return CH_DIG_0 + CH_BITS'(v);
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + CH_BITS'(v - 10);
	endfunction

	// mostly well-formed numbers for the current radix, random content
	task automatic queue_number();
		logic [RADIX_BITS-1:0] b;
		int unsigned n;
		next_first = 1'b1;
		repeat ($urandom_range(0, 3))
			put_char($urandom_range(0, 2) == 0 ? CH_SPACE : CH_BITS'($urandom_range(CH_TAB, CH_CR)));
		case ($urandom_range(0, 3))
			0: put_char(CH_MINUS);
			1: put_char(CH_PLUS);
			default: ;
		endcase
		b = radix_setting;
		if (b == BASE_AUTO || b == BASE_HEX) begin
			case ($urandom_range(0, 3))
				0: begin
					put_char(CH_DIG_0);
					put_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
					b = BASE_HEX;
				end
				1: begin
					if (b == BASE_AUTO) begin
						put_char(CH_DIG_0);
						b = BASE_OCT;
					end
				end
				default: ;
			endcase
		end
		if (b < BASE_MIN || b > RADIX_MAX)
			b = BASE_DEC;
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 70) : $urandom_range(0, 10);
		repeat (n)
			put_char(digit_char($urandom_range(0, b - 1)));
		case ($urandom_range(0, 4))
			0, 1: put_char(CH_NUL);
			2: put_char(CH_BITS'($urandom_range(0, 255)));
			3: put_char(CH_SPACE);
			default: ; // left open, the next string abandons it
		endcase
	endtask

	task automatic queue_noise();
		repeat ($urandom_range(1, 4))
			queue_char(CH_BITS'($urandom_range(0, 255)), $urandom_range(0, 1));
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (chars_pending.size() != 0 || have_next || in_valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_BITS-1:0] r);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		radix_setting = r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int unsigned mark;
		int k;
		logic [RADIX_BITS-1:0] r;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset radix: signs, limits, overflow, no digits, abandoned string, idle bytes
		queue_text(" \t-42", CH_LOWER_X);
		queue_text("9223372036854775807", CH_NUL);
		queue_text("-9223372036854775808", CH_COMMA);
		queue_text("-99999999999999999999", CH_NUL);
		queue_text("+", CH_NUL);
		queue_text("12", CH_NUL, 1'b0);
		queue_text("7", CH_NUL);
		queue_char(CH_DIG_9, 1'b0);
		queue_char(8'hFF, 1'b1);
		wait_quiet();

		write_radix(BASE_AUTO);
		queue_text("0x1f", CH_UPPER_Z);
		queue_text("0X", CH_NUL);
		queue_text("017", CH_SPACE);
		queue_text("09", CH_NUL);
		queue_text("-55", CH_NUL);
		wait_quiet();

		write_radix(BASE_HEX);
		queue_text("0xfffffffffffffffff", CH_NUL);
		queue_text("-0x8000000000000000", CH_NUL);
		queue_text("0x", "g");
		queue_text("Ab", CH_NUL);
		wait_quiet();

		write_radix(RADIX_MAX);
		queue_text("zZ", CH_BANG);
		wait_quiet();
		write_radix(BASE_MIN);
		queue_text("-101", "2");
		wait_quiet();
		write_radix(RADIX_ONE);
		queue_text("5", "5");
		wait_quiet();
		write_radix(6'd63);
		queue_text("7", CH_NUL);
		wait_quiet();

		for (k = 0; k < 12; k++) begin
			case (k)
				0: r = BASE_AUTO;
				1: r = BASE_HEX;
				2: r = BASE_MIN;
				3: r = RADIX_MAX;
				4: r = BASE_OCT;
				5: r = BASE_DEC;
				default: r = ($urandom_range(0, 4) == 0) ? RADIX_BITS'($urandom_range(0, 63))
					: RADIX_BITS'($urandom_range(2, 36));
			endcase
			write_radix(r);
			tx_idle_on = (k % 3 != 2);
			rx_idle_on = (k % 4 != 3);
			// back-to-back words against a stuck receiver fill the block
			if (k == 6) begin
				hold_phase = 1'b1;
				tx_idle_on = 1'b0;
			end
			mark = items_queued;
			while (items_queued - mark < PHASE_ITEMS) begin
				if ($urandom_range(0, 7) == 0)
					queue_noise();
				queue_number();
			end
			wait_quiet();
			hold_phase = 1'b0;
		end

		write_radix(RADIX_RESET);
		wait_quiet();
		if (mismatches == 0)
			$display("string_to_long_parser_unit_test: PASS");
		else
			$display("string_to_long_parser_unit_test: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
design/slp_pkg.sv
design/slp_front.sv
design/slp_fifo.sv
design/slp_back.sv
design/string_to_long_parser_unit.sv
sim/string_to_long_parser_unit_test.sv
